// ===== hdl/dlsc_pkg.sv =====
// Package for the dark line split centroid block.
// Holds shared constants, register indexes and the sequencer state type.
// Also holds the divider control struct. No dependencies.
package dlsc_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;
   localparam int FRAC_BITS_DEF  = 4;

   localparam int CFG_W       = 8;
   localparam int THRESH_W    = 10;
   localparam int PIXEL_W     = 8;
   localparam int COUNT_OUT_W = 14;
   localparam int MEAN_W      = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CFG_W-1:0]    WIDTH_RESET     = 8'd64;
   localparam logic [CFG_W-1:0]    HEIGHT_RESET    = 8'd64;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 10'd80;
   localparam logic [MEAN_W-1:0]   MEAN_MAX        = 11'd2047;
   localparam int                  AREA_SHIFT      = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD = 2'd2;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_LAUNCH,
      ST_DIVIDE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

endpackage

// ===== hdl/dlsc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on dlsc_pkg for the control struct.
module dlsc_divider
   import dlsc_pkg::*;
#(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_ctrl_type          status,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   always_comb begin
      trial   = {rem_ff, dq_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = (trial >= {1'b0, dvs_ff});
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIVIDEND_W-2:0], qbit};
         rem_in = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign quotient     = dq_ff;

endmodule

// ===== hdl/dark_line_split_centroid.sv =====
// Dark line split centroid: one pixel word per cycle while req_ready is high,
// one result word per frame. After the last pixel of a frame the shared divider
// works out the four means in turn from dividends of DW = sum width + FRAC_BITS
// bits; req_ready is low during that time. A result waiting on rsp_ready stalls
// only the next frame end. Synchronous reset restores the register defaults,
// clears positions and sums and drops any pending result word.
module dark_line_split_centroid
   import dlsc_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_W-1:0]     req_red,
   input  logic [PIXEL_W-1:0]     req_green,
   input  logic [PIXEL_W-1:0]     req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_line_found,
   output logic [COUNT_OUT_W-1:0] rsp_left_count,
   output logic [COUNT_OUT_W-1:0] rsp_right_count,
   output logic [MEAN_W-1:0]      rsp_left_row_mean,
   output logic [MEAN_W-1:0]      rsp_left_col_mean,
   output logic [MEAN_W-1:0]      rsp_right_row_mean,
   output logic [MEAN_W-1:0]      rsp_right_col_mean
);

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int AW   = WW + HW;
   localparam int CNTW = $clog2(((MAX_WIDTH + 1) / 2) * MAX_HEIGHT + 1);
   localparam int SUMW = CNTW + ((CW > RW) ? CW : RW);
   localparam int DW   = SUMW + FRAC_BITS;

   logic [CFG_W-1:0]    fw_ff, fh_ff;
   logic [THRESH_W-1:0] thr_ff;

   seq_state_type state_ff, state_in;

   logic [CW-1:0]   col_ff, col_in;
   logic [RW-1:0]   row_ff, row_in;
   logic [CNTW-1:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [SUMW-1:0] lrow_ff, lrow_in, lcol_ff, lcol_in;
   logic [SUMW-1:0] rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [1:0]      sel_ff, sel_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [COUNT_OUT_W-1:0] lcnt_out_ff, lcnt_out_in, rcnt_out_ff, rcnt_out_in;
   logic [MEAN_W-1:0]      mean_ff [4];
   logic [MEAN_W-1:0]      mean_val;

   logic [WW-1:0]       w;
   logic [HW-1:0]       h;
   logic [THRESH_W-1:0] pix_sum;
   logic                dark;
   logic                row_end;
   logic                frame_end;
   logic                accept;
   logic [CNTW:0]       total;
   logic [AW-1:0]       area;

   logic                div_start;
   logic [DW-1:0]       div_dividend;
   logic [CNTW-1:0]     div_divisor;
   logic [SUMW-1:0]     sel_sum;
   logic [CNTW-1:0]     sel_cnt;
   div_ctrl_type        div_status;
   logic [DW-1:0]       div_quot;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= WIDTH_RESET;
         fh_ff  <= HEIGHT_RESET;
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:    fw_ff  <= csr_data[CFG_W-1:0];
            CSR_FRAME_HEIGHT:   fh_ff  <= csr_data[CFG_W-1:0];
            CSR_DARK_THRESHOLD: thr_ff <= csr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped frame size
   always_comb begin
      if (fw_ff < 8'd2) begin
         w = WW'(2);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(fw_ff);
      end
      if (fh_ff == 8'd0) begin
         h = HW'(1);
      end else if (32'(fh_ff) > MAX_HEIGHT) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(fh_ff);
      end
   end

   assign pix_sum   = THRESH_W'(req_red) + THRESH_W'(req_green) + THRESH_W'(req_blue);
   assign dark      = (pix_sum < thr_ff);
   assign row_end   = (WW'(col_ff) >= w - 1'b1);
   assign frame_end = row_end && (HW'(row_ff) >= h - 1'b1);
   assign req_ready = (state_ff == ST_ACCUM);
   assign accept    = req_valid && req_ready;

   assign total = {1'b0, lcnt_ff} + {1'b0, rcnt_ff};
   assign area  = (AW'(w) * AW'(h)) >> AREA_SHIFT;

   always_comb begin
      case (sel_ff)
         2'd0: begin sel_sum = lrow_ff; sel_cnt = lcnt_ff; end
         2'd1: begin sel_sum = lcol_ff; sel_cnt = lcnt_ff; end
         2'd2: begin sel_sum = rrow_ff; sel_cnt = rcnt_ff; end
         default: begin sel_sum = rcol_ff; sel_cnt = rcnt_ff; end
      endcase
   end

   assign div_dividend = DW'(sel_sum) << FRAC_BITS;
   assign div_divisor  = (sel_cnt == '0) ? CNTW'(1) : sel_cnt;
   assign mean_val     = (div_quot > DW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(div_quot);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      lrow_in      = lrow_ff;
      lcol_in      = lcol_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      lcnt_out_in  = lcnt_out_ff;
      rcnt_out_in  = rcnt_out_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            if (accept) begin
               if (dark) begin
                  if (WW'(col_ff) < (w >> 1)) begin
                     lcnt_in = lcnt_ff + 1'b1;
                     lrow_in = lrow_ff + SUMW'(row_ff);
                     lcol_in = lcol_ff + SUMW'(col_ff);
                  end else begin
                     rcnt_in = rcnt_ff + 1'b1;
                     rrow_in = rrow_ff + SUMW'(row_ff);
                     rcol_in = rcol_ff + SUMW'(col_ff);
                  end
               end
               if (!row_end) begin
                  col_in = col_ff + 1'b1;
               end else begin
                  col_in = '0;
                  if (!frame_end) begin
                     row_in = row_ff + 1'b1;
                  end else begin
                     row_in   = '0;
                     sel_in   = 2'd0;
                     state_in = ST_LAUNCH;
                  end
               end
            end
         end
         ST_LAUNCH: begin
            if (!rsp_valid_ff) begin
               found_in    = (AW'(total) > AW'(w)) && (AW'(total) <= area)
                             && (lcnt_ff != '0) && (rcnt_ff != '0);
               lcnt_out_in = COUNT_OUT_W'(lcnt_ff);
               rcnt_out_in = COUNT_OUT_W'(rcnt_ff);
               div_start   = 1'b1;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (sel_ff == 2'd3) begin
                  lcnt_in      = '0;
                  rcnt_in      = '0;
                  lrow_in      = '0;
                  lcol_in      = '0;
                  rrow_in      = '0;
                  rcol_in      = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_ACCUM;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         col_ff       <= '0;
         row_ff       <= '0;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         lrow_ff      <= '0;
         lcol_ff      <= '0;
         rrow_ff      <= '0;
         rcol_ff      <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         lrow_ff      <= lrow_in;
         lcol_ff      <= lcol_in;
         rrow_ff      <= rrow_in;
         rcol_ff      <= rcol_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      lcnt_out_ff <= lcnt_out_in;
      rcnt_out_ff <= rcnt_out_in;
      if (state_ff == ST_DIVIDE && div_status.done) begin
         mean_ff[sel_ff] <= mean_val;
      end
   end

   dlsc_divider #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (CNTW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quot)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_found     = found_ff;
   assign rsp_left_count     = lcnt_out_ff;
   assign rsp_right_count    = rcnt_out_ff;
   assign rsp_left_row_mean  = mean_ff[0];
   assign rsp_left_col_mean  = mean_ff[1];
   assign rsp_right_row_mean = mean_ff[2];
   assign rsp_right_col_mean = mean_ff[3];

endmodule
